// ===== src/fbd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fbd_pkg
// Shared sizes, codes, tables and helper functions of the page framebuffer
// draw engine.
// ---------------------------------------------------------------------------
package fbd_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
    localparam int ADDR_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int COL_W        = $clog2(PANEL_WIDTH);
    localparam int PAGE_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CNT_W        = $clog2(PANEL_WIDTH + 1);
    localparam int COORD_W      = 12;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord W_SIZE = t_coord'(PANEL_WIDTH);
    localparam t_coord H_SIZE = t_coord'(PANEL_HEIGHT);
    localparam t_coord W_LAST = t_coord'(PANEL_WIDTH - 1);
    localparam t_coord H_LAST = t_coord'(PANEL_HEIGHT - 1);

    // command codes
    localparam logic [2:0] CMD_PIXEL = 3'd0;
    localparam logic [2:0] CMD_HLINE = 3'd1;
    localparam logic [2:0] CMD_VLINE = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // colour operations
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_INVERT = 2'd2;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // top k bits set, low k bits set
    localparam logic [7:0] HIGH_BITS [8] = '{8'h00, 8'h80, 8'hC0, 8'hE0,
                                             8'hF0, 8'hF8, 8'hFC, 8'hFE};
    localparam logic [7:0] LOW_BITS  [8] = '{8'h00, 8'h01, 8'h03, 8'h07,
                                             8'h0F, 8'h1F, 8'h3F, 8'h7F};
    localparam logic [7:0] ALL_BITS  = 8'hFF;

    // Resolved span of one draw, ready to be walked through the store.
    typedef struct packed {
        logic              is_col;
        logic              clipped;
        logic              empty;
        logic [ADDR_W-1:0] start;
        logic [CNT_W-1:0]  count;
        logic [2:0]        lo_bit;
        logic [2:0]        hi_bit;
        logic [7:0]        row_mask;
    } t_span;

    // Byte mask of one page of a vertical span: partial on first and last.
    function automatic logic [7:0] page_mask(input logic [2:0] lo_bit,
                                             input logic [2:0] hi_bit,
                                             input logic first,
                                             input logic last);
        logic [7:0] lo_m;
        logic [7:0] hi_m;
        lo_m = first ? ~LOW_BITS[lo_bit] : ALL_BITS;
        hi_m = last ? ~HIGH_BITS[3'd7 - hi_bit] : ALL_BITS;
        return lo_m & hi_m;
    endfunction

    function automatic logic [7:0] apply_colour(input logic [7:0] data,
                                                input logic [7:0] mask,
                                                input logic [1:0] op);
        logic [7:0] res;
        case (op)
            OP_CLEAR:  res = data & ~mask;
            OP_SET:    res = data | mask;
            OP_INVERT: res = data ^ mask;
            default:   res = data;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/fbd_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fbd_cmd_if / fbd_res_if
// Valid/ready channels carrying draw commands in and result beats out.
// ---------------------------------------------------------------------------
interface fbd_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        cmd;
    logic signed [8:0] x_pos;
    logic signed [8:0] y_pos;
    logic [7:0]        length;
    logic [1:0]        colour_op;
    logic [9:0]        byte_index;

    modport source (output valid, cmd, x_pos, y_pos, length, colour_op, byte_index,
                    input ready);
    modport sink   (input valid, cmd, x_pos, y_pos, length, colour_op, byte_index,
                    output ready);
endinterface

interface fbd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       clipped_away;

    modport source (output valid, read_data, clipped_away, input ready);
    modport sink   (input valid, read_data, clipped_away, output ready);
endinterface
`default_nettype wire

// ===== src/fbd_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fbd_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ---------------------------------------------------------------------------
module fbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/fbd_geom.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fbd_geom
// Two-stage span resolver: rotates a logical pixel or line into a panel
// row or column span, then clips it and derives start address, beat count
// and edge bits.
// ---------------------------------------------------------------------------
module fbd_geom import fbd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_rot,
    input  wire logic              i_horiz,
    input  wire logic              i_pixel,
    input  wire logic signed [8:0] i_x,
    input  wire logic signed [8:0] i_y,
    input  wire logic [7:0]        i_len,
    output t_span                  o_span
);

    // stage 1: rotated span
    logic   r_is_col;
    logic   r_empty;
    t_coord r_fixed;
    t_coord r_lo;
    t_coord r_hi;

    logic   n_is_col;
    logic   n_empty;
    t_coord n_fixed;
    t_coord n_lo;
    t_coord n_hi;

    t_coord xs;
    t_coord ys;
    t_coord ext;

    always_comb begin
        xs       = t_coord'(i_x);
        ys       = t_coord'(i_y);
        ext      = i_pixel ? '0 : t_coord'({{(COORD_W-8){1'b0}}, i_len}) - t_coord'(1);
        n_empty  = !i_pixel && (i_len == 8'd0);
        n_is_col = i_horiz ? i_rot[0] : !i_rot[0];
        unique case (i_rot)
            ROT_90: begin
                if (i_horiz) begin
                    n_fixed = W_LAST - ys;
                    n_lo    = xs;
                    n_hi    = xs + ext;
                end else begin
                    n_fixed = xs;
                    n_lo    = W_LAST - ys - ext;
                    n_hi    = W_LAST - ys;
                end
            end
            ROT_180: begin
                if (i_horiz) begin
                    n_fixed = H_LAST - ys;
                    n_lo    = W_LAST - xs - ext;
                    n_hi    = W_LAST - xs;
                end else begin
                    n_fixed = W_LAST - xs;
                    n_lo    = H_LAST - ys - ext;
                    n_hi    = H_LAST - ys;
                end
            end
            ROT_270: begin
                if (i_horiz) begin
                    n_fixed = ys;
                    n_lo    = H_LAST - xs - ext;
                    n_hi    = H_LAST - xs;
                end else begin
                    n_fixed = H_LAST - xs;
                    n_lo    = ys;
                    n_hi    = ys + ext;
                end
            end
            default: begin
                if (i_horiz) begin
                    n_fixed = ys;
                    n_lo    = xs;
                    n_hi    = xs + ext;
                end else begin
                    n_fixed = xs;
                    n_lo    = ys;
                    n_hi    = ys + ext;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_is_col <= n_is_col;
            r_empty  <= n_empty;
            r_fixed  <= n_fixed;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
        end
    end

    // stage 2: clip, clamp, address
    t_coord            fix_max;
    t_coord            span_max;
    t_coord            lo_c;
    t_coord            hi_c;
    logic              off_panel;
    logic [PAGE_W-1:0] page_fix;
    logic [PAGE_W-1:0] page_lo;
    logic [PAGE_W-1:0] page_hi;
    t_span             n_span;
    t_span             r_span;

    always_comb begin
        fix_max   = r_is_col ? W_SIZE : H_SIZE;
        span_max  = r_is_col ? H_SIZE : W_SIZE;
        off_panel = (r_fixed < 0) || (r_fixed >= fix_max) || (r_hi < 0) || (r_lo >= span_max);
        lo_c      = (r_lo < 0) ? '0 : r_lo;
        hi_c      = (r_hi > span_max - t_coord'(1)) ? span_max - t_coord'(1) : r_hi;
        page_fix  = r_fixed[PAGE_W+2:3];
        page_lo   = lo_c[PAGE_W+2:3];
        page_hi   = hi_c[PAGE_W+2:3];

        n_span.is_col   = r_is_col;
        n_span.empty    = r_empty;
        n_span.clipped  = off_panel && !r_empty;
        n_span.lo_bit   = lo_c[2:0];
        n_span.hi_bit   = hi_c[2:0];
        n_span.row_mask = 8'd1 << r_fixed[2:0];
        if (r_is_col) begin
            n_span.start = ADDR_W'(page_lo * PANEL_WIDTH) + ADDR_W'(r_fixed[COL_W-1:0]);
            n_span.count = CNT_W'(page_hi - page_lo) + CNT_W'(1);
        end else begin
            n_span.start = ADDR_W'(page_fix * PANEL_WIDTH) + ADDR_W'(lo_c[COL_W-1:0]);
            n_span.count = CNT_W'(hi_c - lo_c + t_coord'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_span <= n_span;
    end

    assign o_span = r_span;

endmodule
`default_nettype wire

// ===== src/page_framebuffer_draw_engine_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// page_framebuffer_draw_engine_core
// Draw engine over a monochrome page-organized framebuffer held in one RAM:
// pixels, clipped lines under rotation, clear and byte read-back.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake      Beat contents
// i_cmd     in   valid/ready    cmd, x_pos, y_pos, length, colour_op, byte_index
// o_res     out  valid/ready    read_data, clipped_away
// i_cfg     in   write enable   rotation (2 bits), taken on any cycle
//
// Pixel or line: S_GEOM and S_SPAN resolve the span, S_RUN walks the store
// bytes touched (up to PANEL_WIDTH for a horizontal span, PAGE_COUNT for a
// vertical one) at one per cycle, then S_DONE hands over the result: the
// single RAM port pair does one read-modify-write per cycle. Read goes through
// S_READ. Clear and the zeroing pass after reset (ready low) sweep all
// STORE_BYTES (1024) bytes in S_CLEAR. One command is in flight at a time; a
// finished result waits in the output register while the next is taken.
// ---------------------------------------------------------------------------
module page_framebuffer_draw_engine_core import fbd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    fbd_cmd_if.sink         i_cmd,
    fbd_res_if.source       o_res
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GEOM,
        S_SPAN,
        S_RUN,
        S_READ,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [1:0]        r_rotation;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_count;
    logic              r_sweep_cmd;
    logic              r_is_col;
    logic              r_first;
    logic [2:0]        r_lo_bit;
    logic [2:0]        r_hi_bit;
    logic [7:0]        r_row_mask;
    logic [1:0]        r_op;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [7:0]        r_wr_mask;
    logic [7:0]        r_res_data;
    logic              r_res_clip;
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    logic              r_out_clip;

    logic              cmd_accept;
    logic              draw_cmd;
    logic              idx_in_range;
    logic              out_load;
    logic [7:0]        beat_mask;
    logic [ADDR_W-1:0] step;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    t_span             span;

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign cmd_accept   = i_cmd.valid && i_cmd.ready;
    assign draw_cmd     = (i_cmd.cmd == CMD_PIXEL) || (i_cmd.cmd == CMD_HLINE)
                          || (i_cmd.cmd == CMD_VLINE);
    assign idx_in_range = 32'(i_cmd.byte_index) < STORE_BYTES;
    assign out_load     = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    assign beat_mask    = r_is_col ? page_mask(r_lo_bit, r_hi_bit, r_first, r_count == CNT_W'(1))
                                   : r_row_mask;
    assign step         = r_is_col ? ADDR_W'(PANEL_WIDTH) : ADDR_W'(1);

    fbd_geom u_geom (
        .i_clk   (i_clk),
        .i_start (cmd_accept && draw_cmd),
        .i_rot   (r_rotation),
        .i_horiz (i_cmd.cmd != CMD_VLINE),
        .i_pixel (i_cmd.cmd == CMD_PIXEL),
        .i_x     (i_cmd.x_pos),
        .i_y     (i_cmd.y_pos),
        .i_len   (i_cmd.length),
        .o_span  (span)
    );

    // write-back comes in the cycle after the read
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = 8'd0;
        end else begin
            ram_we    = r_wr_pend;
            ram_waddr = r_wr_addr;
            ram_wdata = apply_colour(ram_rdata, r_wr_mask, r_op);
        end
        ram_raddr = (r_state == S_RUN) ? r_addr : ADDR_W'(i_cmd.byte_index);
    end

    fbd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rotation  <= ROT_0;
            r_addr      <= '0;
            r_sweep_cmd <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rotation <= i_cfg_wdata;
            end
            r_wr_pend   <= 1'b0;
            r_out_valid <= out_load || (r_out_valid && !o_res.ready);
            if (out_load) begin
                r_out_data <= r_res_data;
                r_out_clip <= r_res_clip;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    if (r_addr == ADDR_W'(STORE_BYTES - 1)) begin
                        r_state <= r_sweep_cmd ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cmd_accept) begin
                        r_res_data <= 8'd0;
                        r_res_clip <= 1'b0;
                        r_op       <= i_cmd.colour_op;
                        if (draw_cmd) begin
                            r_state <= S_GEOM;
                        end else if (i_cmd.cmd == CMD_CLEAR) begin
                            r_addr      <= '0;
                            r_sweep_cmd <= 1'b1;
                            r_state     <= S_CLEAR;
                        end else if (i_cmd.cmd == CMD_READ && idx_in_range) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_GEOM: begin
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    r_res_clip <= span.clipped;
                    if (span.clipped || span.empty) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr     <= span.start;
                        r_count    <= span.count;
                        r_is_col   <= span.is_col;
                        r_lo_bit   <= span.lo_bit;
                        r_hi_bit   <= span.hi_bit;
                        r_row_mask <= span.row_mask;
                        r_first    <= 1'b1;
                        r_state    <= S_RUN;
                    end
                end
                S_RUN: begin
                    // read this byte now, write it back next cycle
                    r_wr_pend <= 1'b1;
                    r_wr_addr <= r_addr;
                    r_wr_mask <= beat_mask;
                    r_addr    <= r_addr + step;
                    r_count   <= r_count - CNT_W'(1);
                    r_first   <= 1'b0;
                    if (r_count == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_res_data <= ram_rdata;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.read_data    = r_out_data;
    assign o_res.clipped_away = r_out_clip;

    // a new command never lands on top of an unfinished write-back
    a_no_pending_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_accept |-> !r_wr_pend)
        else $error("command accepted with a store write still pending");

    // the read and the write-back of one span never hit the same byte
    a_run_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && r_wr_pend |-> r_addr != r_wr_addr)
        else $error("span read overlaps pending write-back");

    a_run_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> r_count != '0)
        else $error("span walk entered with zero beats");

    a_run_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_count == CNT_W'(1)) |=> (r_state == S_DONE) && r_wr_pend)
        else $error("last span beat did not hand over to result stage");

endmodule
`default_nettype wire

// ===== tb/fbd_draw_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fbd_draw_checker
// Watches the command and result channels of the draw engine and keeps its
// own copy of the framebuffer and rotation. Every accepted command is
// rendered into that copy, and the byte and clip flag it should produce are
// queued. Every accepted result beat is compared with the oldest one queued.
// ---------------------------------------------------------------------------
module fbd_draw_checker import fbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    fbd_cmd_if         i_cmd,
    fbd_res_if         i_res,
    output int         o_fail_count,
    output int         o_results_due
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped_away;
    } fb_reply_t;

    logic [7:0] shadow_fb [STORE_BYTES];
    logic [1:0] shadow_rot;
    fb_reply_t  replies_due [$];

    function automatic logic [7:0] recolour(input logic [7:0] data,
                                            input logic [7:0] mask,
                                            input logic [1:0] op);
        logic [7:0] res;
        res = data;
        if (op == OP_CLEAR)
            res = data & ~mask;
        else if (op == OP_SET)
            res = data | mask;
        else if (op == OP_INVERT)
            res = data ^ mask;
        return res;
    endfunction

    // Fixed panel row, columns lo..hi: one bit in each byte.
    task automatic paint_row(input int row, input int lo, input int hi,
                             input logic [1:0] op, output logic off);
        int first;
        int last;
        int addr;
        first = (lo < 0) ? 0 : lo;
        last  = (hi > PANEL_WIDTH - 1) ? PANEL_WIDTH - 1 : hi;
        off   = (row < 0 || row >= PANEL_HEIGHT || hi < 0 || lo >= PANEL_WIDTH);
        if (!off) begin
            for (int c = first; c <= last; c++) begin
                addr = (row >>> 3) * PANEL_WIDTH + c;
                shadow_fb[addr] = recolour(shadow_fb[addr], 8'(1 << (row & 7)), op);
            end
        end
    endtask

    // Fixed panel column, rows lo..hi: one masked byte per page.
    task automatic paint_col(input int col, input int lo, input int hi,
                             input logic [1:0] op, output logic off);
        int first;
        int last;
        int a;
        int b;
        int addr;
        logic [7:0] full;
        logic [7:0] mask;
        full  = 8'hFF;
        first = (lo < 0) ? 0 : lo;
        last  = (hi > PANEL_HEIGHT - 1) ? PANEL_HEIGHT - 1 : hi;
        off   = (col < 0 || col >= PANEL_WIDTH || hi < 0 || lo >= PANEL_HEIGHT);
        if (!off) begin
            for (int p = first >>> 3; p <= (last >>> 3); p++) begin
                a = (first > p * 8) ? first - p * 8 : 0;
                b = (last < p * 8 + 7) ? last - p * 8 : 7;
                mask = (full << a) & (full >> (7 - b));
                addr = p * PANEL_WIDTH + col;
                shadow_fb[addr] = recolour(shadow_fb[addr], mask, op);
            end
        end
    endtask

    // Map a logical line through the rotation onto a panel row or column.
    task automatic paint_line(input int x, input int y, input int n,
                              input logic horiz, input logic [1:0] op,
                              output logic off);
        int e;
        int wl;
        int hl;
        e   = n - 1;
        wl  = PANEL_WIDTH - 1;
        hl  = PANEL_HEIGHT - 1;
        off = 1'b0;
        if (n > 0) begin
            case (shadow_rot)
                ROT_90: begin
                    if (horiz) paint_col(wl - y, x, x + e, op, off);
                    else       paint_row(x, wl - y - e, wl - y, op, off);
                end
                ROT_180: begin
                    if (horiz) paint_row(hl - y, wl - x - e, wl - x, op, off);
                    else       paint_col(wl - x, hl - y - e, hl - y, op, off);
                end
                ROT_270: begin
                    if (horiz) paint_col(y, hl - x - e, hl - x, op, off);
                    else       paint_row(hl - x, y, y + e, op, off);
                end
                default: begin
                    if (horiz) paint_row(y, x, x + e, op, off);
                    else       paint_col(x, y, y + e, op, off);
                end
            endcase
        end
    endtask

    task automatic render_command();
        fb_reply_t r;
        logic      off;
        int        x;
        int        y;
        int        n;
        r   = '0;
        off = 1'b0;
        x   = int'(i_cmd.x_pos);
        y   = int'(i_cmd.y_pos);
        n   = int'(i_cmd.length);
        case (i_cmd.cmd)
            CMD_PIXEL: paint_line(x, y, 1, 1'b1, i_cmd.colour_op, off);
            CMD_HLINE: paint_line(x, y, n, 1'b1, i_cmd.colour_op, off);
            CMD_VLINE: paint_line(x, y, n, 1'b0, i_cmd.colour_op, off);
            CMD_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
            CMD_READ: begin
                if (int'(i_cmd.byte_index) < STORE_BYTES)
                    r.read_data = shadow_fb[i_cmd.byte_index];
            end
            default: ;
        endcase
        r.clipped_away = off;
        replies_due.push_back(r);
    endtask

    task automatic check_reply();
        fb_reply_t want;
        if (replies_due.size() == 0) begin
            if (o_fail_count < 10)
                $display("%0t: result beat with nothing expected: read_data %02h clipped_away %0b",
                         $time, i_res.read_data, i_res.clipped_away);
            o_fail_count++;
        end else begin
            want = replies_due.pop_front();
            if (i_res.read_data !== want.read_data
                    || i_res.clipped_away !== want.clipped_away) begin
                if (o_fail_count < 10)
                    $display("%0t: mismatch: read_data exp %02h got %02h, clipped_away exp %0b got %0b",
                             $time, want.read_data, i_res.read_data,
                             want.clipped_away, i_res.clipped_away);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_fb[i]) shadow_fb[i] = '0;
            shadow_rot = ROT_0;
            replies_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we)
                shadow_rot = i_cfg_wdata;
            // pop before push so a stray beat is never matched to a new command
            if (i_res.valid && i_res.ready)
                check_reply();
            if (i_cmd.valid && i_cmd.ready)
                render_command();
        end
        o_results_due = replies_due.size();
    end

endmodule

// ===== tb/page_framebuffer_draw_engine_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_framebuffer_draw_engine_core_test
// Drives the draw engine with a directed set of pixels, lines, clears and
// reads, then random commands under every rotation, with random gaps and
// stalls on both channels. A side checker predicts and compares each beat.
// ---------------------------------------------------------------------------
module page_framebuffer_draw_engine_core_test;
    import fbd_pkg::*;

    localparam longint LIMIT_NS   = 20_000_000;
    localparam int     PHASE_ITEMS = 250;

    typedef struct {
        logic [2:0]        cmd;
        logic signed [8:0] x_pos;
        logic signed [8:0] y_pos;
        logic [7:0]        length;
        logic [1:0]        colour_op;
        logic [9:0]        byte_index;
    } draw_cmd_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    int         fail_count;
    int         results_due;
    bit         no_gaps;
    int         hold_requests;
    int         holds_served;
    int         hold_left;

    fbd_cmd_if cmd_bus ();
    fbd_res_if res_bus ();

    page_framebuffer_draw_engine_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd_bus),
        .o_res       (res_bus)
    );

    fbd_draw_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_cmd         (cmd_bus),
        .i_res         (res_bus),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic draw_cmd_t mk(input logic [2:0] c, input int x, input int y,
                                     input int n, input logic [1:0] op, input int idx);
        draw_cmd_t d;
        d.cmd        = c;
        d.x_pos      = 9'(x);
        d.y_pos      = 9'(y);
        d.length     = 8'(n);
        d.colour_op  = op;
        d.byte_index = 10'(idx);
        return d;
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t d;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            d.cmd = CMD_PIXEL;
        else if (pick < 45)
            d.cmd = CMD_HLINE;
        else if (pick < 65)
            d.cmd = CMD_VLINE;
        else if (pick < 67)
            d.cmd = CMD_CLEAR;
        else if (pick < 95)
            d.cmd = CMD_READ;
        else
            d.cmd = 3'(CMD_READ + $urandom_range(1, 3));
        // mostly on or just past the panel, now and then anywhere
        if ($urandom_range(0, 3) == 0) begin
            d.x_pos = 9'($urandom);
            d.y_pos = 9'($urandom);
        end else begin
            d.x_pos = 9'(int'($urandom_range(0, 139)) - 6);
            d.y_pos = 9'(int'($urandom_range(0, 139)) - 6);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
            d.length = 8'($urandom_range(1, 24));
        else if (pick < 92)
            d.length = 8'($urandom);
        else
            d.length = '0;
        if ($urandom_range(0, 7) == 0)
            d.colour_op = 2'($urandom);
        else
            d.colour_op = 2'($urandom_range(OP_CLEAR, OP_INVERT));
        d.byte_index = 10'($urandom);
        return d;
    endfunction

    // Present one command and hold it until the beat is taken.
    task automatic offer(input draw_cmd_t d);
        while (!no_gaps && $urandom_range(0, 99) < 32) begin
            @(negedge clk);
            cmd_bus.valid = 1'b0;
        end
        @(negedge clk);
        cmd_bus.valid      = 1'b1;
        cmd_bus.cmd        = d.cmd;
        cmd_bus.x_pos      = d.x_pos;
        cmd_bus.y_pos      = d.y_pos;
        cmd_bus.length     = d.length;
        cmd_bus.colour_op  = d.colour_op;
        cmd_bus.byte_index = d.byte_index;
        do @(posedge clk); while (!cmd_bus.ready);
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        wait (results_due == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_rotation(input logic [1:0] rot);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = rot;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // result side: random stalls, plus long hold-offs on request
    initial begin
        res_bus.ready = 1'b0;
        holds_served  = 0;
        hold_left     = 0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready = 1'b0;
            end else begin
                res_bus.ready = no_gaps || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        draw_cmd_t  directed [$];
        logic [1:0] phase_rot [7];

        phase_rot = '{ROT_90, ROT_180, ROT_270, ROT_0, ROT_270, ROT_90, ROT_180};
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = ROT_0;
        no_gaps            = 1'b0;
        hold_requests      = 0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.cmd        = CMD_PIXEL;
        cmd_bus.x_pos      = '0;
        cmd_bus.y_pos      = '0;
        cmd_bus.length     = '0;
        cmd_bus.colour_op  = OP_CLEAR;
        cmd_bus.byte_index = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_rotation(ROT_0);
        directed.push_back(mk(CMD_READ,    0,    0,   0, OP_CLEAR,  0));
        directed.push_back(mk(CMD_PIXEL,   0,    0,   0, OP_SET,    0));
        directed.push_back(mk(CMD_PIXEL,   127,  63,  0, OP_SET,    0));
        directed.push_back(mk(CMD_READ,    0,    0,   0, OP_SET,    1023));
        directed.push_back(mk(CMD_PIXEL,   128,  0,   0, OP_SET,    0));
        directed.push_back(mk(CMD_PIXEL,   -1,   64,  0, OP_INVERT, 0));
        // wholly off the left, then clipped on both ends
        directed.push_back(mk(CMD_HLINE,   -256, 0,   255, OP_SET,  0));
        directed.push_back(mk(CMD_HLINE,   -10,  9,   255, OP_SET,  0));
        directed.push_back(mk(CMD_HLINE,   255,  -256, 255, OP_INVERT, 0));
        // partial first and last page masks
        directed.push_back(mk(CMD_VLINE,   5,    -3,  20, OP_SET,   0));
        directed.push_back(mk(CMD_VLINE,   6,    3,   3,  OP_SET,   0));
        directed.push_back(mk(CMD_VLINE,   5,    2,   10, OP_INVERT, 0));
        directed.push_back(mk(CMD_READ,    0,    0,   0, OP_SET,    133));
        directed.push_back(mk(CMD_READ,    0,    0,   0, OP_SET,    261));
        // zero length, even far off the panel
        directed.push_back(mk(CMD_VLINE,   7,    0,   0, OP_SET,    0));
        directed.push_back(mk(CMD_HLINE,   200,  5,   0, OP_SET,    0));
        // colour three leaves bits alone but still reports clipping
        directed.push_back(mk(CMD_PIXEL,   0,    9,   0, 2'(OP_INVERT + 1), 0));
        directed.push_back(mk(CMD_PIXEL,   -256, 9,   0, 2'(OP_INVERT + 1), 0));
        directed.push_back(mk(CMD_PIXEL,   0,    9,   0, OP_CLEAR,  0));
        directed.push_back(mk(CMD_READ,    0,    0,   0, OP_SET,    128));
        directed.push_back(mk(3'(CMD_READ + 1), 1, 1, 1, OP_SET,    5));
        directed.push_back(mk(3'(CMD_READ + 3), 1, 1, 1, OP_SET,    5));
        directed.push_back(mk(CMD_CLEAR,   0,    0,   0, OP_SET,    0));
        directed.push_back(mk(CMD_READ,    0,    0,   0, OP_SET,    5));
        foreach (directed[i])
            offer(directed[i]);

        for (int ph = 0; ph < 7; ph++) begin
            set_rotation(phase_rot[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == 10)
                    hold_requests++;
                if (ph == 2 && k == 120)
                    drain();
                no_gaps = (ph == 0 && k >= 60 && k < 200);
                offer(random_cmd());
            end
        end
        no_gaps = 1'b0;

        drain();
        repeat (STORE_BYTES + 16) @(posedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
